@@ rtl/core/crbs_pkg.sv @@
package crbs_pkg;

    localparam int DatW = 32;
    localparam int BszW = 17;
    localparam int MulW = DatW + BszW;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FILE_SIZE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_START_OFFSET = 2'd2;

    localparam logic [BszW-1:0] BLOCK_SIZE_RESET = 17'd128;

    // signatures, first byte in the low byte
    localparam logic [DatW-1:0] SIG_URL = 32'h204C5255;  // "URL "
    localparam logic [DatW-1:0] SIG_HASH = 32'h48534148; // "HASH"
    localparam logic [DatW-1:0] SIG_REDR = 32'h52444552; // "REDR"
    localparam logic [DatW-1:0] SIG_LEAK = 32'h4B41454C; // "LEAK"

    typedef enum logic [2:0] {
        KIND_ALLOC   = 3'd0,
        KIND_RECOV   = 3'd1,
        KIND_PARTIAL = 3'd2,
        KIND_TAINT   = 3'd3,
        KIND_ADVANCE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        TYPE_UNDEF = 2'd0,
        TYPE_URL   = 2'd1,
        TYPE_REDIR = 2'd2,
        TYPE_LEAK  = 2'd3
    } t_itype;

    typedef struct packed {
        logic [DatW-1:0] signature;
        logic [DatW-1:0] header_blocks;
        logic            in_unallocated;
    } t_in_item;

    typedef struct packed {
        t_kind           kind;
        t_itype          rec_type;
        logic [DatW-1:0] item_offset;
        logic [DatW-1:0] item_size;
        logic [DatW-1:0] next_offset;
        logic            scan_done;
        logic            last;
    } t_out_item;

    typedef struct packed {
        logic            done;
        logic [MulW-1:0] product;
    } t_mul_stat;

    typedef struct packed {
        logic   detected;
        t_itype itype;
    } t_sig_class;

    function automatic t_sig_class sig_decode(input logic [DatW-1:0] sig);
        t_sig_class c;
        c.detected = 1'b1;
        c.itype = TYPE_UNDEF;
        if (sig == SIG_URL) begin
            c.itype = TYPE_URL;
        end else if (sig == SIG_HASH) begin
            c.itype = TYPE_UNDEF;
        end else if (sig == SIG_REDR) begin
            c.itype = TYPE_REDIR;
        end else if (sig == SIG_LEAK) begin
            c.itype = TYPE_LEAK;
        end else begin
            c.detected = 1'b0;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/crbs_mul.sv @@
module crbs_mul
    import crbs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DatW-1:0] i_mcand,
    input  logic [BszW-1:0] i_mplier,
    output t_mul_stat       o_stat
);

    localparam int CntW = $clog2(BszW);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [MulW-1:0] r_acc;
    logic [MulW-1:0] r_mcand;
    logic [BszW-1:0] r_mplier;

    // one multiplier bit per cycle through a single adder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(BszW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mcand <= MulW'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.product = r_acc;

endmodule

@@ rtl/core/cache_record_block_scanner.sv @@
// Record block scanner for a cache file.
// Input channel (i_in_valid / o_in_stall) takes one record header request: the
// signature, block count and unallocated flag read at the offset last announced.
// Output channel (o_out_valid / i_out_stall) returns one to three result
// requests per header: taint or partial recovered, then allocated or recovered,
// then an advance with the next offset and done flag; the advance has last set.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 block
// size, 1 file size, 2 start offset). Writing the start offset starts a scan.
// Sequence: after accept, a header passes through the shift-add multiplier that
// forms block count times block size, the registering of its done flag, the
// range check and the result build before its first result; results are then
// offered in turn, each held until taken. A header read past the end of the
// file gives its single advance on the cycle after accept. o_in_stall stays
// high from accept until the advance is taken; one header is in flight at a
// time, so a new header is taken only after the previous advance is taken.
// A stalling receiver holds the current result; nothing is dropped.
// Reset: block size 128, file size and start offset 0, scan state cleared,
// channel idle and ready.
module cache_record_block_scanner
    import crbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DatW-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_BUILD,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [BszW-1:0] r_bsz;
    logic [DatW-1:0] r_fsz;

    // scan state
    logic [DatW-1:0] r_cur;
    logic [DatW-1:0] r_rem;
    logic [DatW-1:0] r_hrs;
    logic [DatW-1:0] r_hbc;
    t_itype          r_pend;
    logic            r_hp;

    // latched header
    logic            r_det;
    t_itype          r_new_type;
    logic            r_unal;
    logic [DatW-1:0] r_blocks;
    logic [DatW-1:0] r_size;

    t_out_item       r_res [3];

    logic [BszW-1:0] bs;
    t_sig_class      in_cls;
    logic            in_take;
    logic            out_take;
    logic [DatW-1:0] blocks0;
    logic            at_end;
    logic            mul_start;
    t_mul_stat       mul_stat;
    t_out_item       res_end;

    assign bs = (r_bsz == '0) ? BszW'(1) : r_bsz;
    assign in_cls = sig_decode(i_in_data.signature);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_data = r_res[0];
    assign out_take = o_out_valid && !i_out_stall;
    assign at_end = (r_cur >= r_fsz);
    assign mul_start = in_take && !at_end;

    // block count before the range check
    always_comb begin
        if (in_cls.detected) begin
            blocks0 = i_in_data.header_blocks;
        end else if (r_rem == '0) begin
            blocks0 = DatW'(1);
        end else begin
            blocks0 = r_hbc;
        end
    end

    // lone advance for a header read past the end of the file
    always_comb begin
        res_end = '0;
        res_end.kind = KIND_ADVANCE;
        res_end.next_offset = r_cur;
        res_end.scan_done = 1'b1;
        res_end.last = 1'b1;
    end

    crbs_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (blocks0),
        .i_mplier (bs),
        .o_stat   (mul_stat)
    );

    // range check: blocks > (file length - offset) / bs  <=>  blocks * bs > that span
    logic [DatW-1:0] span;
    logic            forced;

    assign span = r_fsz - r_cur;
    assign forced = (r_blocks == '0) || (mul_stat.product > MulW'(span));

    // result build from latched header and scan state
    logic            rem_z;
    logic            taint_v;
    logic            part_v;
    logic            ab_v;
    t_itype          pend0;
    t_itype          pend1;
    t_itype          n_pend;
    logic [DatW-1:0] psize;
    logic [DatW-1:0] rem1;
    logic [DatW-1:0] rem2;
    logic [DatW-1:0] n_rem;
    logic [DatW-1:0] n_hrs;
    logic [DatW:0]   next_w;
    logic [DatW-1:0] n_cur;
    logic            n_hp;
    t_out_item       res_a;
    t_out_item       res_b;
    t_out_item       res_adv;

    always_comb begin
        rem_z = (r_rem == '0);
        taint_v = r_hp && rem_z && !r_det;
        pend0 = (!r_det && rem_z) ? TYPE_UNDEF : r_pend;
        part_v = r_det && !rem_z;
        psize = r_hrs - r_rem;
        pend1 = r_det ? r_new_type : pend0;
        rem1 = r_det ? '0 : r_rem;
        n_hp = part_v;
        n_pend = pend1;
        ab_v = 1'b0;
        rem2 = rem1;
        n_hrs = r_hrs;

        res_a = '0;
        res_b = '0;
        res_adv = '0;
        if (taint_v) begin
            res_a.kind = KIND_TAINT;
        end else begin
            res_a.kind = KIND_PARTIAL;
            res_a.rec_type = r_pend;
            res_a.item_offset = r_cur - psize;
            res_a.item_size = psize;
        end

        res_b.kind = KIND_ALLOC;
        res_b.rec_type = pend1;
        if (rem1 == '0) begin
            n_hrs = r_size;
            if (pend1 != TYPE_UNDEF) begin
                if (!r_unal) begin
                    ab_v = 1'b1;
                    res_b.item_offset = r_cur;
                    res_b.item_size = r_size;
                    n_hp = 1'b1;
                    n_pend = TYPE_UNDEF;
                end else begin
                    rem2 = r_size;
                end
            end
        end

        n_rem = rem2;
        if (rem2 == '0) begin
            next_w = {1'b0, r_cur} + {1'b0, n_hrs};
        end else begin
            next_w = {1'b0, r_cur} + (DatW + 1)'(bs);
            n_rem = (rem2 >= DatW'(bs)) ? rem2 - DatW'(bs) : '0;
            if (n_rem == '0) begin
                // record walked to its end: recover it whole
                ab_v = 1'b1;
                res_b.kind = KIND_RECOV;
                res_b.rec_type = n_pend;
                res_b.item_offset = next_w[DatW-1:0] - n_hrs;
                res_b.item_size = n_hrs;
                n_hp = 1'b1;
                n_pend = TYPE_UNDEF;
            end
        end

        // saturate offset at the top of the space
        n_cur = next_w[DatW] ? '1 : next_w[DatW-1:0];
        res_adv.kind = KIND_ADVANCE;
        res_adv.next_offset = n_cur;
        res_adv.scan_done = (n_cur >= r_fsz);
        res_adv.last = 1'b1;
    end

    // sequencer, configuration and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bsz <= BLOCK_SIZE_RESET;
            r_fsz <= '0;
            r_cur <= '0;
            r_rem <= '0;
            r_hrs <= '0;
            r_hbc <= '0;
            r_pend <= TYPE_UNDEF;
            r_hp <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= at_end ? S_EMIT : S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_stat.done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= S_BUILD;
                end
                S_BUILD: begin
                    r_state <= S_EMIT;
                    r_cur <= n_cur;
                    r_rem <= n_rem;
                    r_hrs <= n_hrs;
                    r_hbc <= r_blocks;
                    r_pend <= n_pend;
                    r_hp <= n_hp;
                end
                S_EMIT: begin
                    if (out_take && r_res[0].last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_SIZE: r_bsz <= i_cfg_data[BszW-1:0];
                    CFG_FILE_SIZE: r_fsz <= i_cfg_data;
                    CFG_START_OFFSET: begin
                        // new scan: load offset, drop all record state
                        r_cur <= i_cfg_data;
                        r_rem <= '0;
                        r_hrs <= '0;
                        r_hbc <= '0;
                        r_pend <= TYPE_UNDEF;
                        r_hp <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // header latch, checked count and result queue
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_det <= in_cls.detected;
            r_new_type <= in_cls.itype;
            r_unal <= i_in_data.in_unallocated;
            r_blocks <= blocks0;
            if (at_end) begin
                r_res[0] <= res_end;
            end
        end
        if (r_state == S_CHECK) begin
            r_blocks <= forced ? DatW'(1) : r_blocks;
            r_size <= forced ? DatW'(bs) : mul_stat.product[DatW-1:0];
        end
        if (r_state == S_BUILD) begin
            // pack present results to the head of the queue
            if (taint_v || part_v) begin
                r_res[0] <= res_a;
                r_res[1] <= ab_v ? res_b : res_adv;
            end else begin
                r_res[0] <= ab_v ? res_b : res_adv;
                r_res[1] <= res_adv;
            end
            r_res[2] <= res_adv;
        end
        if (out_take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    a_more_after_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !o_out_data.last) |=> o_out_valid)
        else $error("result run broken before its advance");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_out_data.last) |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after final advance");

    a_last_is_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.kind == KIND_ADVANCE))
        else $error("last result is not an advance");

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its phase");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |=> (r_state == S_MUL && !o_out_valid))
        else $error("multiply started without header in flight");

endmodule
